// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the frame statistics monitor RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/wfsm_pkg.sv =====
// Shared constants for the WLAN frame statistics monitor.
// No dependencies.
`default_nettype none

package wfsm_pkg;

    localparam int HISTORY_DEPTH_DEF = 128;

    localparam logic [15:0] INTERVAL_RST = 16'd250;
    localparam logic [15:0] FLOOR_RST    = 16'd10;

    localparam logic       REG_INTERVAL = 1'b0;
    localparam logic       REG_FLOOR    = 1'b1;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] CLASS_MGMT = 2'd0;
    localparam logic [1:0] CLASS_CTRL = 2'd1;
    localparam logic [1:0] CLASS_DATA = 2'd2;

    localparam logic [7:0] SUBTYPE_MASK = 8'hF0;
    localparam logic [7:0] SUB_DEAUTH   = 8'hC0;
    localparam logic [7:0] SUB_DISASSOC = 8'hA0;

    localparam logic [9:0]  RATE_MULT = 10'd1000;
    localparam logic [15:0] RATE_SAT  = 16'hFFFF;

    localparam logic [7:0] MEAN_NONE = 8'h81;  // -127
    localparam logic [7:0] MEAN_MIN  = 8'h80;  // -128
    localparam logic [7:0] MEAN_MAX  = 8'h7F;  // 127

endpackage

`default_nettype wire

// ===== rtl/wlan_frame_statistics_monitor.sv =====
// Frame statistics monitor: counters, sample rate/mean dividers, rate history memory.
// Depends on wfsm_pkg and assert_macros.svh.
// Sequence: frame, clear and non-sampling tick words pass through S_EXEC and S_DONE to the
//   output register; a sampling tick adds S_MUL, S_PREP, 16 divider steps and S_WRITE,
//   then one history memory read per entry (S_WALK, S_WTAIL) to rebuild the peak.
// Flow: one item in flight at a time; a new word is accepted only in S_IDLE.
// Reset: synchronous, active low; counters zero, mean -127, history empty, registers 250/10.
`default_nettype none
`include "assert_macros.svh"

module wlan_frame_statistics_monitor #(
    parameter int HISTORY_DEPTH = wfsm_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [1:0]        i_kind,
    input  wire logic [31:0]       i_now_ms,
    input  wire logic [1:0]        i_frame_class,
    input  wire logic [7:0]        i_frame_first_byte,
    input  wire logic [11:0]       i_frame_length,
    input  wire logic signed [7:0] i_frame_rssi,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [31:0]            o_total_frames,
    output logic [31:0]            o_mgmt_frames,
    output logic [31:0]            o_ctrl_frames,
    output logic [31:0]            o_payload_frames,
    output logic [31:0]            o_deauth_frames,
    output logic [15:0]            o_frames_per_second,
    output logic signed [7:0]      o_mean_rssi,
    output logic [15:0]            o_history_peak,
    output logic                   o_sample_taken
);
    import wfsm_pkg::*;

    localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = AW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_PREP  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_WRITE = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_WTAIL = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]  r_state;
    logic [15:0] r_interval, r_floor;

    logic [31:0] r_cnt_total, r_cnt_mgmt, r_cnt_ctrl, r_cnt_payload, r_cnt_deauth;
    logic [47:0] r_rssi_acc;
    logic [31:0] r_rssi_frames, r_last_time, r_total_at_last;
    logic [15:0] r_rate;
    logic [7:0]  r_mean;
    logic [15:0] r_hist_max;
    logic [AW-1:0]     r_wptr, r_waddr;
    logic [FILL_W-1:0] r_fill;
    logic [3:0]  r_step;
    logic        r_sampled;

    // item and datapath registers
    logic [1:0]  r_kind, r_cls;
    logic [31:0] r_now;
    logic [7:0]  r_first, r_rssi;
    logic [11:0] r_len;
    logic [31:0] r_elapsed, r_delta;
    logic [41:0] r_prod;
    logic [47:0] r_mag;
    logic        r_neg, r_has, r_rsat, r_msat;
    logic [31:0] r_rrem, r_mrem;
    logic [15:0] r_rlo, r_rq;
    logic [7:0]  r_mlo, r_mq;

    logic [15:0] r_hist_mem [HISTORY_DEPTH];
    logic [15:0] r_rd_data;
    logic        r_rd_ok;

    logic [15:0] w_interval;
    logic [31:0] w_elapsed;
    logic [32:0] w_rtry, w_mtry, w_rsub, w_msub;
    logic        w_rge, w_mge;
    logic [15:0] w_rate;
    logic [7:0]  w_mean;
    logic [47:0] w_rssi_ext;
    logic        w_mem_we;

    assign o_ready    = (r_state == S_IDLE);
    assign w_interval = (r_interval == 16'd0) ? 16'd1 : r_interval;
    assign w_elapsed  = r_now - r_last_time;
    assign w_rssi_ext = {{40{r_rssi[7]}}, r_rssi};
    assign w_mem_we   = (r_state == S_WRITE);

    assign w_rtry = {r_rrem, r_rlo[15]};
    assign w_rsub = w_rtry - {1'b0, r_elapsed};
    assign w_rge  = (w_rtry >= {1'b0, r_elapsed});
    assign w_mtry = {r_mrem, r_mlo[7]};
    assign w_msub = w_mtry - {1'b0, r_rssi_frames};
    assign w_mge  = (w_mtry >= {1'b0, r_rssi_frames});

    assign w_rate = r_rsat ? RATE_SAT : r_rq;

    always_comb begin
        if (!r_has) begin
            w_mean = MEAN_NONE;
        end else if (r_msat) begin
            w_mean = r_neg ? MEAN_MIN : MEAN_MAX;
        end else if (r_neg) begin
            w_mean = (r_mq > 8'd128) ? MEAN_MIN : (~r_mq + 8'd1);
        end else begin
            w_mean = (r_mq > 8'd127) ? MEAN_MAX : r_mq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_interval      <= INTERVAL_RST;
            r_floor         <= FLOOR_RST;
            r_cnt_total     <= '0;
            r_cnt_mgmt      <= '0;
            r_cnt_ctrl      <= '0;
            r_cnt_payload   <= '0;
            r_cnt_deauth    <= '0;
            r_rssi_acc      <= '0;
            r_rssi_frames   <= '0;
            r_last_time     <= '0;
            r_total_at_last <= '0;
            r_rate          <= '0;
            r_mean          <= MEAN_NONE;
            r_hist_max      <= '0;
            r_wptr          <= '0;
            r_waddr         <= '0;
            r_fill          <= '0;
            r_step          <= '0;
            r_sampled       <= 1'b0;
            o_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_INTERVAL: r_interval <= i_cfg_data;
                    REG_FLOOR:    r_floor    <= i_cfg_data;
                endcase
            end
            if (o_valid && i_ready && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_sampled <= 1'b0;
                    r_state   <= S_DONE;
                    unique case (r_kind)
                        KIND_FRAME: begin
                            if (r_len != 12'd0) begin
                                r_cnt_total   <= r_cnt_total + 32'd1;
                                r_rssi_acc    <= r_rssi_acc + w_rssi_ext;
                                r_rssi_frames <= r_rssi_frames + 32'd1;
                                unique case (r_cls)
                                    CLASS_MGMT: begin
                                        r_cnt_mgmt <= r_cnt_mgmt + 32'd1;
                                        if ((r_first & SUBTYPE_MASK) == SUB_DEAUTH ||
                                            (r_first & SUBTYPE_MASK) == SUB_DISASSOC) begin
                                            r_cnt_deauth <= r_cnt_deauth + 32'd1;
                                        end
                                    end
                                    CLASS_CTRL: r_cnt_ctrl    <= r_cnt_ctrl + 32'd1;
                                    CLASS_DATA: r_cnt_payload <= r_cnt_payload + 32'd1;
                                    default: ;
                                endcase
                            end
                        end
                        KIND_TICK: begin
                            if (w_elapsed >= {16'd0, w_interval}) begin
                                r_state <= S_MUL;
                            end
                        end
                        KIND_CLEAR: begin
                            r_cnt_total     <= '0;
                            r_cnt_mgmt      <= '0;
                            r_cnt_ctrl      <= '0;
                            r_cnt_payload   <= '0;
                            r_cnt_deauth    <= '0;
                            r_rssi_acc      <= '0;
                            r_rssi_frames   <= '0;
                            r_last_time     <= r_now;
                            r_total_at_last <= '0;
                            r_rate          <= '0;
                            r_mean          <= MEAN_NONE;
                            r_hist_max      <= '0;
                            r_wptr          <= '0;
                            r_fill          <= '0;
                        end
                        default: ;
                    endcase
                end
                S_MUL: begin
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_rate          <= w_rate;
                    r_mean          <= w_mean;
                    r_total_at_last <= r_cnt_total;
                    r_last_time     <= r_now;
                    r_sampled       <= 1'b1;
                    r_hist_max      <= '0;
                    r_waddr         <= '0;
                    r_wptr <= (r_wptr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
                    if (r_fill != FILL_W'(HISTORY_DEPTH)) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_rd_ok && r_rd_data > r_hist_max) begin
                        r_hist_max <= r_rd_data;
                    end
                    r_waddr <= r_waddr + AW'(1);
                    if (r_waddr == AW'(HISTORY_DEPTH - 1)) begin
                        r_state <= S_WTAIL;
                    end
                end
                S_WTAIL: begin
                    if (r_rd_ok && r_rd_data > r_hist_max) begin
                        r_hist_max <= r_rd_data;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_kind  <= i_kind;
            r_now   <= i_now_ms;
            r_cls   <= i_frame_class;
            r_first <= i_frame_first_byte;
            r_len   <= i_frame_length;
            r_rssi  <= i_frame_rssi;
        end
        if (r_state == S_EXEC) begin
            r_elapsed <= w_elapsed;
            r_delta   <= r_cnt_total - r_total_at_last;
            r_neg     <= r_rssi_acc[47];
            r_mag     <= r_rssi_acc[47] ? (~r_rssi_acc + 48'd1) : r_rssi_acc;
            r_has     <= (r_rssi_frames != 32'd0);
        end
        if (r_state == S_MUL) begin
            r_prod <= {10'd0, r_delta} * {32'd0, RATE_MULT};
        end
        if (r_state == S_PREP) begin
            r_rsat <= ({6'd0, r_prod[41:16]} >= r_elapsed);
            r_msat <= (r_mag[47:8] >= {8'd0, r_rssi_frames});
            r_rrem <= {6'd0, r_prod[41:16]};
            r_rlo  <= r_prod[15:0];
            r_mrem <= r_mag[39:8];
            r_mlo  <= r_mag[7:0];
        end
        if (r_state == S_DIV) begin
            r_rrem <= w_rge ? w_rsub[31:0] : w_rtry[31:0];
            r_rlo  <= {r_rlo[14:0], 1'b0};
            r_rq   <= {r_rq[14:0], w_rge};
            if (r_step < 4'd8) begin
                r_mrem <= w_mge ? w_msub[31:0] : w_mtry[31:0];
                r_mlo  <= {r_mlo[6:0], 1'b0};
                r_mq   <= {r_mq[6:0], w_mge};
            end
        end
        if (r_state == S_DONE && (!o_valid || i_ready)) begin
            o_total_frames      <= r_cnt_total;
            o_mgmt_frames       <= r_cnt_mgmt;
            o_ctrl_frames       <= r_cnt_ctrl;
            o_payload_frames    <= r_cnt_payload;
            o_deauth_frames     <= r_cnt_deauth;
            o_frames_per_second <= r_rate;
            o_mean_rssi         <= r_mean;
            o_history_peak      <= (r_hist_max > r_floor) ? r_hist_max : r_floor;
            o_sample_taken      <= r_sampled;
        end
    end

    // rate history: circular buffer, entries at or past the fill count are ignored by the peak walk
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_hist_mem[r_wptr] <= w_rate;
        end
        r_rd_data <= r_hist_mem[r_waddr];
        r_rd_ok   <= (r_state == S_WALK) && ({1'b0, r_waddr} < r_fill);
    end

    `ASSERT_CLK(a_fill_bound, r_fill <= FILL_W'(HISTORY_DEPTH), "history fill count overflow")
    `ASSERT_CLK(a_accept_busy, (i_valid && o_ready) |=> (r_state == S_EXEC), "accept not taken")
    `ASSERT_CLK(a_walk_no_write, (r_state == S_WALK || r_state == S_WTAIL) |-> !w_mem_we,
                "history written during peak walk")
    `ASSERT_CLK(a_result_src, $rose(o_valid) |-> $past(r_state == S_DONE),
                "result word without finished item")
    `ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE && !o_valid),
                   "reset did not idle the block")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for wlan_frame_statistics_monitor: directed table, then random phases over register
// settings; words checked against typed rows or an in-bench model of counters, samples, history.
// Depends on wfsm_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;
    import wfsm_pkg::*;

    localparam int          HIST        = HISTORY_DEPTH_DEF;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0]  KIND_NONE   = 2'd3;
    localparam logic [1:0]  CLASS_OTHER = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [1:0]  cls;
        logic [7:0]  first_byte;
        logic [11:0] length;
        logic [7:0]  rssi;
    } frame_word_t;

    typedef struct packed {
        logic [31:0] total;
        logic [31:0] mgmt;
        logic [31:0] ctrl;
        logic [31:0] payload;
        logic [31:0] deauth;
        logic [15:0] fps;
        logic [7:0]  mean;
        logic [15:0] peak;
        logic        sampled;
    } stats_t;

    typedef struct packed {
        frame_word_t w;
        logic        typed;
        stats_t      r;
    } row_t;

    localparam stats_t IDLE_SNAPSHOT =
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, MEAN_NONE, FLOOR_RST, 1'b0};
    localparam stats_t NO_STATS = '0;

    localparam int DIR_ROWS = 23;
    localparam row_t DIRECTED [DIR_ROWS] = '{
        '{'{KIND_NONE, 32'hFFFF_FFFF, CLASS_OTHER, 8'hFF, 12'hFFF, 8'h80}, 1'b1, IDLE_SNAPSHOT},
        '{'{KIND_FRAME, 32'd0, CLASS_MGMT, 8'hC0, 12'd0, 8'h7F}, 1'b1, IDLE_SNAPSHOT},
        '{'{KIND_TICK, 32'd249, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b1, IDLE_SNAPSHOT},
        '{'{KIND_FRAME, 32'd0, CLASS_MGMT, 8'hC5, 12'd1, 8'h7F}, 1'b1,
          '{32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 16'd0, MEAN_NONE, FLOOR_RST, 1'b0}},
        '{'{KIND_FRAME, 32'd0, CLASS_MGMT, 8'hA0, 12'hFFF, 8'h80}, 1'b1,
          '{32'd2, 32'd2, 32'd0, 32'd0, 32'd2, 16'd0, MEAN_NONE, FLOOR_RST, 1'b0}},
        '{'{KIND_FRAME, 32'd0, CLASS_MGMT, 8'h50, 12'd100, 8'hFF}, 1'b1,
          '{32'd3, 32'd3, 32'd0, 32'd0, 32'd2, 16'd0, MEAN_NONE, FLOOR_RST, 1'b0}},
        '{'{KIND_FRAME, 32'd0, CLASS_CTRL, 8'hC0, 12'd20, 8'hD8}, 1'b0, NO_STATS},
        '{'{KIND_FRAME, 32'd0, CLASS_DATA, 8'h08, 12'd1500, 8'hC4}, 1'b0, NO_STATS},
        '{'{KIND_FRAME, 32'd0, CLASS_OTHER, 8'hB0, 12'd60, 8'h00}, 1'b0, NO_STATS},
        '{'{KIND_TICK, 32'd250, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b0, NO_STATS},
        '{'{KIND_FRAME, 32'd0, CLASS_DATA, 8'h88, 12'd300, 8'hBA}, 1'b0, NO_STATS},
        '{'{KIND_TICK, 32'hFFFF_FFFF, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b0, NO_STATS},
        '{'{KIND_TICK, 32'd0, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b0, NO_STATS},
        '{'{KIND_CLEAR, 32'hFFFF_FF00, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b1, IDLE_SNAPSHOT},
        '{'{KIND_FRAME, 32'd0, CLASS_DATA, 8'h08, 12'd512, 8'h80}, 1'b0, NO_STATS},
        '{'{KIND_FRAME, 32'd0, CLASS_MGMT, 8'hCF, 12'd24, 8'h05}, 1'b0, NO_STATS},
        '{'{KIND_TICK, 32'h0000_0100, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b0, NO_STATS},
        '{'{KIND_NONE, 32'd0, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b0, NO_STATS},
        '{'{KIND_TICK, 32'h0000_01F9, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b0, NO_STATS},
        '{'{KIND_CLEAR, 32'd0, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b1, IDLE_SNAPSHOT},
        '{'{KIND_TICK, 32'd250, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b1,
          '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, MEAN_NONE, FLOOR_RST, 1'b1}},
        '{'{KIND_FRAME, 32'd0, CLASS_MGMT, 8'hF0, 12'd1, 8'h7F}, 1'b0, NO_STATS},
        '{'{KIND_TICK, 32'hFFFF_FFFF, CLASS_MGMT, 8'h00, 12'd0, 8'h00}, 1'b0, NO_STATS}
    };

    // random phases: interval, floor, tick percentage, words
    localparam int PHASES = 4;
    localparam int PH_TICK_PCT [PHASES] = '{25, 25, 1, 15};
    localparam int PH_WORDS [PHASES]    = '{250, 200, 150, 400};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_INTERVAL;
    logic [15:0] i_cfg_data = 16'd0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind = KIND_FRAME;
    logic [31:0] i_now_ms = 32'd0;
    logic [1:0]  i_frame_class = CLASS_MGMT;
    logic [7:0]  i_frame_first_byte = 8'd0;
    logic [11:0] i_frame_length = 12'd0;
    logic signed [7:0] i_frame_rssi = 8'sd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_total_frames;
    logic [31:0] o_mgmt_frames;
    logic [31:0] o_ctrl_frames;
    logic [31:0] o_payload_frames;
    logic [31:0] o_deauth_frames;
    logic [15:0] o_frames_per_second;
    logic signed [7:0] o_mean_rssi;
    logic [15:0] o_history_peak;
    logic        o_sample_taken;

    wlan_frame_statistics_monitor DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_kind              (i_kind),
        .i_now_ms            (i_now_ms),
        .i_frame_class       (i_frame_class),
        .i_frame_first_byte  (i_frame_first_byte),
        .i_frame_length      (i_frame_length),
        .i_frame_rssi        (i_frame_rssi),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_total_frames      (o_total_frames),
        .o_mgmt_frames       (o_mgmt_frames),
        .o_ctrl_frames       (o_ctrl_frames),
        .o_payload_frames    (o_payload_frames),
        .o_deauth_frames     (o_deauth_frames),
        .o_frames_per_second (o_frames_per_second),
        .o_mean_rssi         (o_mean_rssi),
        .o_history_peak      (o_history_peak),
        .o_sample_taken      (o_sample_taken)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model state
    logic [15:0] cfg_interval;
    logic [15:0] cfg_floor;
    logic [31:0] n_total, n_mgmt, n_ctrl, n_payload, n_deauth;
    logic [47:0] rssi_sum;
    logic [31:0] rssi_count;
    logic [31:0] sample_ms;
    logic [31:0] total_at_sample;
    logic [15:0] rate_now;
    logic [7:0]  mean_now;
    logic [15:0] rate_hist [HIST];

    stats_t      pending_stats [$];
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    logic [31:0] wall_ms = 32'd0;

    function automatic void clear_stats(logic [31:0] now);
        n_total = '0;
        n_mgmt = '0;
        n_ctrl = '0;
        n_payload = '0;
        n_deauth = '0;
        rssi_sum = '0;
        rssi_count = '0;
        sample_ms = now;
        total_at_sample = '0;
        rate_now = '0;
        mean_now = MEAN_NONE;
        for (int i = 0; i < HIST; i++) rate_hist[i] = '0;
    endfunction

    function automatic stats_t predict_stats(frame_word_t w);
        stats_t      s;
        logic [31:0] interval;
        logic [31:0] elapsed;
        logic [31:0] delta;
        logic [63:0] quo;
        longint      sum_s;
        longint      cnt_s;
        longint      mean_s;
        logic [15:0] peak;
        logic        sampled;

        sampled = 1'b0;
        case (w.kind)
            KIND_FRAME: begin
                if (w.length != 0) begin
                    n_total++;
                    case (w.cls)
                        CLASS_MGMT: begin
                            n_mgmt++;
                            if ((w.first_byte & SUBTYPE_MASK) == SUB_DEAUTH ||
                                (w.first_byte & SUBTYPE_MASK) == SUB_DISASSOC)
                                n_deauth++;
                        end
                        CLASS_CTRL: n_ctrl++;
                        CLASS_DATA: n_payload++;
                        default: ;
                    endcase
                    rssi_sum = rssi_sum + {{40{w.rssi[7]}}, w.rssi};
                    rssi_count++;
                end
            end
            KIND_TICK: begin
                interval = (cfg_interval == 0) ? 32'd1 : {16'd0, cfg_interval};
                elapsed = w.now_ms - sample_ms;
                if (elapsed >= interval) begin
                    delta = n_total - total_at_sample;
                    quo = (64'(delta) * 64'd1000) / 64'(elapsed);
                    rate_now = (quo > 64'd65535) ? RATE_SAT : quo[15:0];
                    if (rssi_count != 0) begin
                        sum_s = longint'($signed(rssi_sum));
                        cnt_s = rssi_count;
                        mean_s = sum_s / cnt_s;
                        if (mean_s > 127) mean_s = 127;
                        if (mean_s < -128) mean_s = -128;
                        mean_now = mean_s[7:0];
                    end else begin
                        mean_now = MEAN_NONE;
                    end
                    for (int i = 1; i < HIST; i++) rate_hist[i - 1] = rate_hist[i];
                    rate_hist[HIST - 1] = rate_now;
                    total_at_sample = n_total;
                    sample_ms = w.now_ms;
                    sampled = 1'b1;
                end
            end
            KIND_CLEAR: clear_stats(w.now_ms);
            default: ;
        endcase

        peak = cfg_floor;
        for (int i = 0; i < HIST; i++)
            if (rate_hist[i] > peak) peak = rate_hist[i];

        s = '{n_total, n_mgmt, n_ctrl, n_payload, n_deauth, rate_now, mean_now, peak, sampled};
        return s;
    endfunction

    function automatic frame_word_t random_word(int tick_pct, logic [15:0] ivl);
        frame_word_t w;
        int          r;
        logic [31:0] span;

        w.kind = KIND_FRAME;
        w.now_ms = $urandom;
        w.cls = 2'($urandom_range(0, 3));
        w.first_byte = 8'($urandom);
        w.length = 12'($urandom_range(1, 4095));
        w.rssi = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 3) begin
            w.kind = KIND_NONE;
            w.length = 12'($urandom);
        end else if (r < 5) begin
            w.kind = KIND_CLEAR;
            if ($urandom_range(0, 1) == 0) w.now_ms = wall_ms;
            wall_ms = w.now_ms;
        end else if (r < 5 + tick_pct) begin
            w.kind = KIND_TICK;
            case ($urandom_range(0, 9))
                0, 1, 2: span = (ivl == 0) ? 32'd0 : $urandom_range(0, ivl - 1);
                9:       span = $urandom;
                default: span = $urandom_range(ivl, 3 * ivl + 2);
            endcase
            wall_ms = wall_ms + span;
            w.now_ms = wall_ms;
        end else begin
            if ($urandom_range(0, 3) == 0)
                w.first_byte[7:4] = ($urandom_range(0, 1) == 0) ? 4'hC : 4'hA;
            case ($urandom_range(0, 19))
                0: w.length = 12'd0;
                1: w.length = 12'hFFF;
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic offer(input frame_word_t w, input logic typed, input stats_t typed_r);
        int     gap;
        stats_t pred;

        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_kind <= w.kind;
        i_now_ms <= w.now_ms;
        i_frame_class <= w.cls;
        i_frame_first_byte <= w.first_byte;
        i_frame_length <= w.length;
        i_frame_rssi <= w.rssi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pred = predict_stats(w);
        pending_stats.push_back(typed ? typed_r : pred);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [15:0] ivl;
        logic [15:0] flr;

        cfg_interval = INTERVAL_RST;
        cfg_floor = FLOOR_RST;
        clear_stats(32'd0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++)
            offer(DIRECTED[k].w, DIRECTED[k].typed, DIRECTED[k].r);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin ivl = 16'd0;     flr = 16'd0;     end
                1: begin ivl = 16'hFFFF;  flr = 16'hFFFF;  end
                2: begin ivl = 16'd1;     flr = 16'd0;     end
                default: begin
                    ivl = 16'($urandom_range(1, 1000));
                    flr = 16'($urandom_range(0, 200));
                end
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_idx <= REG_INTERVAL;
            i_cfg_data <= ivl;
            @(posedge i_clk);
            cfg_interval = ivl;
            i_cfg_idx <= REG_FLOOR;
            i_cfg_data <= flr;
            @(posedge i_clk);
            cfg_floor = flr;
            i_cfg_we <= 1'b0;
            @(posedge i_clk);

            for (int k = 0; k < PH_WORDS[p]; k++)
                offer(random_word(PH_TICK_PCT[p], ivl), 1'b0, NO_STATS);
            drain();
        end

        repeat (HIST + 40) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random ready patterns, one long hold-off mid-run
    initial begin
        logic [31:0] pat;
        int          span;
        int          hold;
        logic        held;

        hold = 0;
        held = 1'b0;
        forever begin
            pat = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
            span = $urandom_range(8, 96);
            for (int k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (!held && results_seen >= 300) begin
                    held = 1'b1;
                    hold = 400;
                end
                if (hold > 0) begin
                    hold--;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= pat[k % 32];
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        stats_t got;
        stats_t want;

        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_total_frames, o_mgmt_frames, o_ctrl_frames, o_payload_frames,
                    o_deauth_frames, o_frames_per_second, o_mean_rssi, o_history_peak,
                    o_sample_taken};
            results_seen++;
            if (pending_stats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word at cycle %0d", cycle_count);
            end else begin
                want = pending_stats.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("word %0d mismatch, expected: tot %0d mgmt %0d ctrl %0d data %0d",
                                 results_seen, want.total, want.mgmt, want.ctrl, want.payload);
                        $display("  deauth %0d fps %0d mean %0d peak %0d sample %0d",
                                 want.deauth, want.fps, $signed(want.mean), want.peak,
                                 want.sampled);
                        $display("  actual: tot %0d mgmt %0d ctrl %0d data %0d deauth %0d",
                                 got.total, got.mgmt, got.ctrl, got.payload, got.deauth);
                        $display("  fps %0d mean %0d peak %0d sample %0d",
                                 got.fps, $signed(got.mean), got.peak, got.sampled);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wfsm_pkg.sv
rtl/wlan_frame_statistics_monitor.sv
verif/tb.sv
